>>> rtl/tshd_pkg.sv
`timescale 1ns / 1ps

package tshd_pkg;

	localparam logic [15:0]     MATCH_CODE_RESET = 16'h11A6;
	localparam longint unsigned POSITION_MAX_DEF = 64'd65535;

	// header byte two: version nibble high, offset in words low
	localparam logic [3:0] VER_V4      = 4'd4;
	localparam logic [3:0] VER_V6      = 4'd6;
	localparam logic [3:0] OFFS_V4     = 4'd2;
	localparam logic [3:0] OFFS_V6     = 4'd5;
	localparam logic [5:0] HLEN_MIN    = 6'd8;

	// result queue depth; one processed byte pushes at most two results
	localparam int RQ_DEPTH = 4;

	typedef enum logic [1:0] {
		KIND_ADDR    = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_STATUS  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_APP     = 3'd1,
		ST_BAD_VERSION = 3'd2,
		ST_MALFORMED   = 3'd3,
		ST_TOO_SHORT   = 3'd4
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [3:0]  version;
		status_t     status;
		logic        last;
	} result_t;

endpackage

>>> rtl/tshd_parse.sv
`timescale 1ns / 1ps

module tshd_parse #(
	parameter longint unsigned POSITION_MAX = tshd_pkg::POSITION_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [15:0]       match_code,
	input  logic              fire,
	input  logic [7:0]        data_byte,
	input  logic              eop,
	output tshd_pkg::result_t res0,
	output tshd_pkg::result_t res1,
	output logic [1:0]        res_cnt
);
	import tshd_pkg::*;

	localparam int             PosW   = $clog2(POSITION_MAX + 64'd1);
	localparam logic [PosW-1:0] PosMax = PosW'(POSITION_MAX);

	logic [PosW-1:0] pos_q;
	logic [7:0]      code_hi_q;
	logic            code_ok_q;
	logic [7:0]      vo_byte_q;

	logic            code_ok;
	logic [7:0]      vo_byte;
	logic [3:0]      ver;
	logic [3:0]      offs;
	logic [5:0]      hlen;
	logic [PosW-1:0] hlen_p;
	logic [PosW:0]   len;
	logic            hdr_good;
	logic            emit_data;
	status_t         st;
	result_t         data_res;
	result_t         stat_res;

	// state as seen after this byte updates it
	always_comb begin
		code_ok = code_ok_q;
		vo_byte = vo_byte_q;
		if (pos_q == PosW'(1)) begin
			code_ok = ({code_hi_q, data_byte} == match_code);
		end
		if (pos_q == PosW'(2)) begin
			vo_byte = data_byte;
		end
	end

	assign ver      = vo_byte[7:4];
	assign offs     = vo_byte[3:0];
	assign hlen     = {offs, 2'b00};
	assign hlen_p   = PosW'(hlen);
	assign len      = {1'b0, pos_q} + (PosW+1)'(1);
	assign hdr_good = code_ok && (((ver == VER_V4) && (offs == OFFS_V4)) ||
		((ver == VER_V6) && (offs == OFFS_V6)));
	assign emit_data = (pos_q >= PosW'(4)) && hdr_good;

	always_comb begin
		if (pos_q < PosW'(2)) begin
			st = ST_TOO_SHORT;
		end else if (!code_ok) begin
			st = ST_BAD_APP;
		end else if (hlen < HLEN_MIN) begin
			st = ST_MALFORMED;
		end else if ((PosW+1)'(hlen) > len) begin
			st = ST_TOO_SHORT;
		end else if ((ver != VER_V4) && (ver != VER_V6)) begin
			st = ST_BAD_VERSION;
		end else if (((ver == VER_V4) && (offs != OFFS_V4)) ||
			((ver == VER_V6) && (offs != OFFS_V6))) begin
			st = ST_MALFORMED;
		end else begin
			st = ST_OK;
		end
	end

	always_comb begin
		data_res.kind    = (pos_q < hlen_p) ? KIND_ADDR : KIND_PAYLOAD;
		data_res.data    = data_byte;
		data_res.version = ver;
		data_res.status  = ST_OK;
		data_res.last    = 1'b0;

		stat_res.kind    = KIND_STATUS;
		stat_res.data    = 8'd0;
		stat_res.version = ver;
		stat_res.status  = st;
		stat_res.last    = 1'b1;
	end

	// data item always goes first when both are produced
	always_comb begin
		res0    = emit_data ? data_res : stat_res;
		res1    = stat_res;
		res_cnt = 2'd0;
		if (fire) begin
			res_cnt = {1'b0, emit_data} + {1'b0, eop};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			code_hi_q <= '0;
			code_ok_q <= 1'b0;
			vo_byte_q <= '0;
		end else if (fire) begin
			if (eop) begin
				pos_q     <= '0;
				code_hi_q <= '0;
				code_ok_q <= 1'b0;
				vo_byte_q <= '0;
			end else begin
				if (pos_q == '0) begin
					code_hi_q <= data_byte;
				end
				code_ok_q <= code_ok;
				vo_byte_q <= vo_byte;
				if (pos_q < PosMax) begin
					pos_q <= pos_q + PosW'(1);
				end
			end
		end
	end

endmodule

>>> rtl/tshd_rqueue.sv
`timescale 1ns / 1ps

module tshd_rqueue (
	input  logic              clk,
	input  logic              arst_n,
	input  tshd_pkg::result_t push0,
	input  tshd_pkg::result_t push1,
	input  logic [1:0]        push_cnt,
	input  logic              pop,
	output tshd_pkg::result_t head,
	output logic              not_empty,
	output logic [$clog2(tshd_pkg::RQ_DEPTH+1)-1:0] count
);
	import tshd_pkg::*;

	localparam int PtrW = $clog2(RQ_DEPTH);
	localparam int CntW = $clog2(RQ_DEPTH + 1);

	result_t         entry_q [RQ_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_pop;

	assign not_empty = (cnt_q != '0);
	assign do_pop    = pop && not_empty;
	assign head      = entry_q[rd_ptr_q];
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			entry_q[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			entry_q[wr_ptr_q + PtrW'(1)] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PtrW'(push_cnt);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			cnt_q <= cnt_q + CntW'(push_cnt) - CntW'(do_pop);
		end
	end

endmodule

>>> rtl/tagged_source_header_deframer_top.sv
`timescale 1ns / 1ps
// Deframer for packets that carry an application code, a version/offset
// byte and a source address ahead of the payload.
// Input stream: one packet byte per transfer on s_tdata, s_tlast on the
// final byte. Output stream: address bytes (tuser 0), payload bytes
// (tuser 1) and one status item (tuser 2, tlast high) per packet.
// Configuration: cfg_data is the expected application code, loaded on
// cfg_valid; cfg_ready is always high. Write it only while no packet is
// in progress.
// An accepted byte is registered in the input stage, then its results are
// written into the result queue, which drives m_tvalid. Throughput: one byte
// per cycle while the queue has room; the final byte of a packet that also
// carries a data item produces two results, absorbed by the four-entry result queue.
// Reset clears the packet state and the queue and loads the application
// code with 0x11A6. When the receiver stalls the queue fills and s_tready
// drops once fewer than two entries are free; nothing is dropped.
module tagged_source_header_deframer_top #(
	parameter longint unsigned POSITION_MAX = tshd_pkg::POSITION_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tlast,  // end_of_packet
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] out_byte, [11:8] version, [14:12] status, [15] 0
	output logic [1:0]  m_tuser,  // [1:0] item_kind
	output logic        m_tlast,  // last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import tshd_pkg::*;

	localparam int CntW = $clog2(RQ_DEPTH + 1);

	logic [15:0]     match_code_q;
	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            eop_s1;
	logic            fire;
	logic            room;
	result_t         res0;
	result_t         res1;
	logic [1:0]      res_cnt;
	result_t         head;
	logic            not_empty;
	logic [CntW-1:0] rq_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_code_q <= MATCH_CODE_RESET;
		end else if (cfg_valid) begin
			match_code_q <= cfg_data;
		end
	end

	assign room     = (rq_count <= CntW'(RQ_DEPTH - 2));
	assign fire     = valid_s1 && room;
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eop_s1  <= s_tlast;
		end
	end

	tshd_parse #(
		.POSITION_MAX(POSITION_MAX)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.match_code(match_code_q),
		.fire      (fire),
		.data_byte (byte_s1),
		.eop       (eop_s1),
		.res0      (res0),
		.res1      (res1),
		.res_cnt   (res_cnt)
	);

	tshd_rqueue u_rqueue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push0    (res0),
		.push1    (res1),
		.push_cnt (res_cnt),
		.pop      (m_tready),
		.head     (head),
		.not_empty(not_empty),
		.count    (rq_count)
	);

	assign m_tvalid = not_empty;
	assign m_tdata  = {1'b0, head.status, head.version, head.data};
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;

	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_count <= CntW'(RQ_DEPTH))
		else $error("result queue overflow");

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser == KIND_STATUS))
		else $error("tlast on a data item");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire) |=> (valid_s1 && $stable(byte_s1) && $stable(eop_s1)))
		else $error("stalled byte lost");

endmodule

>>> verif/tb_tagged_source_header_deframer_top.sv
`timescale 1ns / 1ps

module tb_tagged_source_header_deframer_top;

	import tshd_pkg::*;

	// small saturation point so that long packets stay cheap
	localparam longint unsigned POS_MAX     = 255;
	localparam int              HLEN_V4     = 8;
	localparam int              HLEN_V6     = 20;
	localparam int              DRAIN_PAUSE = 8;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tlast;   // end_of_packet
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [7:0] out_byte, [11:8] version, [14:12] status, [15] 0
	logic [1:0]  m_tuser;   // [1:0] item_kind
	logic        m_tlast;   // last
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	// deframer state as predicted
	int unsigned pos;
	logic [7:0]  code_hi;
	bit          code_ok;
	logic [7:0]  vo_byte;
	logic [15:0] match_code;

	result_t     expected_out[$];
	int          errors;
	int          sent_bytes;
	bit          quiet;

	tagged_source_header_deframer_top #(
		.POSITION_MAX(POS_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void compare_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	function automatic void clear_packet();
		pos = 0;
		code_hi = '0;
		code_ok = 1'b0;
		vo_byte = '0;
	endfunction

	// expected results of one accepted byte
	task automatic deframe_predict(input logic [7:0] b, input bit eop);
		logic [3:0]  ver;
		logic [3:0]  offs;
		int unsigned hlen;
		int unsigned len;
		status_t     st;
		result_t     r;
		if (pos == 0)
			code_hi = b;
		else if (pos == 1)
			code_ok = ({code_hi, b} == match_code);
		else if (pos == 2)
			vo_byte = b;
		ver = vo_byte[7:4];
		offs = vo_byte[3:0];
		hlen = 4 * int'(offs);
		if (pos >= 4 && code_ok && ((ver == VER_V4 && offs == OFFS_V4) ||
				(ver == VER_V6 && offs == OFFS_V6))) begin
			r.kind = (pos < hlen) ? KIND_ADDR : KIND_PAYLOAD;
			r.data = b;
			r.version = ver;
			r.status = ST_OK;
			r.last = 1'b0;
			expected_out.push_back(r);
		end
		if (eop) begin
			len = pos + 1;
			if (len < 3)
				st = ST_TOO_SHORT;
			else if (!code_ok)
				st = ST_BAD_APP;
			else if (hlen < HLEN_MIN)
				st = ST_MALFORMED;
			else if (hlen > len)
				st = ST_TOO_SHORT;
			else if (ver != VER_V4 && ver != VER_V6)
				st = ST_BAD_VERSION;
			else if (hlen != ((ver == VER_V4) ? HLEN_V4 : HLEN_V6))
				st = ST_MALFORMED;
			else
				st = ST_OK;
			r.kind = KIND_STATUS;
			r.data = '0;
			r.version = ver;
			r.status = st;
			r.last = 1'b1;
			expected_out.push_back(r);
			clear_packet();
		end else if (pos < POS_MAX) begin
			pos++;
		end
	endtask

	// every task of the main thread starts and ends at a rising edge
	task automatic send_byte(input logic [7:0] b, input bit eop);
		int  gap;
		logic rdy;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eop;
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		deframe_predict(b, eop);
		sent_bytes++;
	endtask

	task automatic send_packet(input logic [15:0] code, input logic [7:0] vo, input int len);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			if (i == 0)
				b = code[15:8];
			else if (i == 1)
				b = code[7:0];
			else if (i == 2)
				b = vo;
			else
				b = 8'($urandom);
			send_byte(b, i == len - 1);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	task automatic load_match_code(input logic [15:0] v);
		logic rdy;
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid <= 1'b0;
		match_code = v;
	endtask

	// mostly well-formed headers with random content, some broken or cut short
	task automatic random_packet();
		int          sel;
		int          len;
		logic [15:0] code;
		logic [3:0]  ver;
		logic [3:0]  offs;
		sel = $urandom_range(0, 99);
		code = match_code;
		ver = VER_V4;
		offs = OFFS_V4;
		if (sel >= 35 && sel < 65) begin
			ver = VER_V6;
			offs = OFFS_V6;
		end else if (sel >= 65 && sel < 75) begin
			code = match_code ^ 16'($urandom_range(1, 65535));
			if ($urandom_range(0, 1)) begin
				ver = VER_V6;
				offs = OFFS_V6;
			end
		end else if (sel >= 75 && sel < 85) begin
			do ver = 4'($urandom); while (ver == VER_V4 || ver == VER_V6);
			offs = 4'($urandom);
		end else if (sel >= 85 && sel < 95) begin
			ver = $urandom_range(0, 1) ? VER_V6 : VER_V4;
			do offs = 4'($urandom);
			while (offs == ((ver == VER_V4) ? OFFS_V4 : OFFS_V6));
		end else if (sel >= 95) begin
			code = 16'($urandom);
			ver = 4'($urandom);
			offs = 4'($urandom);
		end
		len = 4 * int'(offs);
		len += ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
		if (len == 0)
			len = 1;
		if ($urandom_range(0, 7) == 0)
			len = $urandom_range(1, len);
		send_packet(code, {ver, offs}, len);
	endtask

	task automatic random_phase(input int n);
		int  target;
		int  mid;
		bit  paused;
		target = sent_bytes + n;
		mid = sent_bytes + n / 2;
		paused = 1'b0;
		while (sent_bytes < target) begin
			random_packet();
			if (!paused && sent_bytes >= mid) begin
				drain_results();
				paused = 1'b1;
			end
		end
	endtask

	task automatic test_directed();
		// one-byte and two-byte packets end before the header byte
		send_byte(8'hFF, 1'b1);
		send_byte(match_code[15:8], 1'b0);
		send_byte(match_code[7:0], 1'b1);
		// shortest good v4 packet: the last address byte and the status together
		send_byte(match_code[15:8], 1'b0);
		send_byte(match_code[7:0], 1'b0);
		send_byte({VER_V4, OFFS_V4}, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b1);
		// cut inside the address: emitted bytes stay, status says too short
		send_byte(match_code[15:8], 1'b0);
		send_byte(match_code[7:0], 1'b0);
		send_byte({VER_V4, OFFS_V4}, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b1);
		// wrong code, three bytes
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte({VER_V6, OFFS_V6}, 1'b1);
	endtask

	task automatic test_back_to_back(input int n);
		quiet = 1'b1;
		random_phase(n);
		quiet = 1'b0;
	endtask

	// a packet past the saturation point of the byte position
	task automatic test_long_packets();
		send_packet(match_code, $urandom_range(0, 1) ? {VER_V6, OFFS_V6} : {VER_V4, OFFS_V4},
			$urandom_range(256, 270));
	endtask

	initial begin : result_monitor
		logic        v;
		logic        r;
		logic [15:0] d;
		logic [1:0]  u;
		logic        l;
		result_t     e;
		forever begin
			@(negedge clk);
			v = m_tvalid;
			r = m_tready;
			d = m_tdata;
			u = m_tuser;
			l = m_tlast;
			@(posedge clk);
			if (v && r && arst_n) begin
				if (expected_out.size() == 0) begin
					$display("%0t: unexpected result expected none actual tuser %0d tdata %h",
						$time, u, d);
					errors++;
				end else begin
					e = expected_out.pop_front();
					compare_field("item_kind", int'(e.kind), int'(u));
					compare_field("out_byte", int'(e.data), int'(d[7:0]));
					compare_field("version", int'(e.version), int'(d[11:8]));
					compare_field("status", int'(e.status), int'(d[14:12]));
					compare_field("tdata pad", 0, int'(d[15]));
					compare_field("last", int'(e.last), int'(l));
				end
			end
		end
	end

	initial begin : sink_stalls
		int n;
		wait (arst_n);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
			n = idle_len();
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0;
		sent_bytes = 0;
		quiet = 1'b0;
		match_code = MATCH_CODE_RESET;
		clear_packet();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		random_phase(120);
		load_match_code(16'h0000);
		random_phase(100);
		load_match_code(16'hFFFF);
		random_phase(100);
		load_match_code(16'($urandom));
		test_back_to_back(80);
		test_long_packets();
		load_match_code(16'($urandom));
		random_phase(120);

		drain_results();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/tshd_pkg.sv
rtl/tshd_parse.sv
rtl/tshd_rqueue.sv
rtl/tagged_source_header_deframer_top.sv
verif/tb_tagged_source_header_deframer_top.sv
